FILE: design/drl_pkg.sv
// Package for the DDA line rasterizer: default sizes, queue depth and item codes.
// Used by drl_front and by the top level dda_line_rasterizer_core.
package drl_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;

    // command queue between front and back, a power of two
    localparam int Q_DEPTH = 4;
    localparam int QP_W    = $clog2(Q_DEPTH);

    // item kinds carried on tuser
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

endpackage

FILE: design/drl_front.sv
// Front end of the DDA line rasterizer: accepts items, classifies loads and advances,
// works out |dx|, |dy| and the step count, and queues the commands. Depends on drl_pkg.
module drl_front #(
    parameter int COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic                  i_mode,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output logic                  o_cmd_load,
    output logic [COORD_BITS-1:0] o_sx,
    output logic [COORD_BITS-1:0] o_sy,
    output logic [COORD_BITS-1:0] o_ax,
    output logic [COORD_BITS-1:0] o_ay,
    output logic                  o_neg_x,
    output logic                  o_neg_y,
    output logic [COORD_BITS-1:0] o_steps
);
    import drl_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int CMD_W = 5 * C + 3;

    logic [C:0]       w_dx;
    logic [C:0]       w_dy;
    logic [C:0]       w_dx_neg;
    logic [C:0]       w_dy_neg;
    logic [C-1:0]     w_ax;
    logic [C-1:0]     w_ay;
    logic [C-1:0]     w_steps;
    logic [CMD_W-1:0] w_entry;
    logic [CMD_W-1:0] w_head;
    logic             w_push;
    logic             w_pop;

    logic [CMD_W-1:0] r_q [Q_DEPTH];
    logic [QP_W-1:0]  r_wr_ptr;
    logic [QP_W-1:0]  r_rd_ptr;
    logic [QP_W:0]    r_cnt;

    // classify: absolute deltas and the major-axis length
    assign w_dx     = {1'b0, i_end_x} - {1'b0, i_start_x};
    assign w_dy     = {1'b0, i_end_y} - {1'b0, i_start_y};
    assign w_dx_neg = -w_dx;
    assign w_dy_neg = -w_dy;
    assign w_ax     = w_dx[C] ? w_dx_neg[C-1:0] : w_dx[C-1:0];
    assign w_ay     = w_dy[C] ? w_dy_neg[C-1:0] : w_dy[C-1:0];
    assign w_steps  = (w_ax > w_ay) ? w_ax : w_ay;

    assign w_entry = {w_steps, w_dy[C], w_dx[C], w_ay, w_ax, i_start_y, i_start_x,
                      (i_mode == MODE_LOAD)};

    assign o_s_tready  = (r_cnt != (QP_W+1)'(Q_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign w_push      = i_s_tvalid && o_s_tready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    assign w_head     = r_q[r_rd_ptr];
    assign o_cmd_load = w_head[0];
    assign o_sx       = w_head[C:1];
    assign o_sy       = w_head[2*C:C+1];
    assign o_ax       = w_head[3*C:2*C+1];
    assign o_ay       = w_head[4*C:3*C+1];
    assign o_neg_x    = w_head[4*C+1];
    assign o_neg_y    = w_head[4*C+2];
    assign o_steps    = w_head[5*C+2:4*C+3];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QP_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QP_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + (QP_W+1)'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - (QP_W+1)'(1);
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QP_W+1)'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + (QP_W+1)'(1)))
        else $error("queue count did not grow on push");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_cnt == $past(r_cnt) - (QP_W+1)'(1)))
        else $error("queue count did not shrink on pop");

endmodule

FILE: design/drl_back.sv
// Back end of the DDA line rasterizer: restoring divider for the Q.FRAC increments,
// position accumulators, pixel rounding and the output register. No package needed.
module drl_back #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  logic                  i_cmd_load,
    input  logic [COORD_BITS-1:0] i_sx,
    input  logic [COORD_BITS-1:0] i_sy,
    input  logic [COORD_BITS-1:0] i_ax,
    input  logic [COORD_BITS-1:0] i_ay,
    input  logic                  i_neg_x,
    input  logic                  i_neg_y,
    input  logic [COORD_BITS-1:0] i_steps,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last_point
);
    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int POS_W = C + 2 + F;
    localparam int INC_W = F + 2;
    localparam int CNT_W = $clog2(F + 1);
    localparam logic [POS_W-1:0] HALF = POS_W'(1) << (F - 1);

    logic             r_busy,   n_busy;
    logic [CNT_W-1:0] r_cnt,    n_cnt;
    logic [C:0]       r_rem_x,  n_rem_x;
    logic [C:0]       r_rem_y,  n_rem_y;
    logic [F:0]       r_q_x,    n_q_x;
    logic [F:0]       r_q_y,    n_q_y;
    logic [C-1:0]     r_steps,  n_steps;
    logic             r_neg_x,  n_neg_x;
    logic             r_neg_y,  n_neg_y;
    logic [POS_W-1:0] r_pos_x,  n_pos_x;
    logic [POS_W-1:0] r_pos_y,  n_pos_y;
    logic [INC_W-1:0] r_inc_x,  n_inc_x;
    logic [INC_W-1:0] r_inc_y,  n_inc_y;
    logic [C:0]       r_pts,    n_pts;
    logic             r_active, n_active;
    logic             r_ovalid, n_ovalid;
    logic [C-1:0]     r_px,     n_px;
    logic [C-1:0]     r_py,     n_py;
    logic             r_olast,  n_olast;

    logic             w_pop;
    logic             w_ge_x;
    logic             w_ge_y;
    logic [C:0]       w_sub_x;
    logic [C:0]       w_sub_y;
    logic [C:0]       w_keep_x;
    logic [C:0]       w_keep_y;
    logic [F:0]       w_qn_x;
    logic [F:0]       w_qn_y;
    logic [POS_W-1:0] w_rnd_x;
    logic [POS_W-1:0] w_rnd_y;

    // loads may pass a stalled output; advances need a free output slot
    assign o_cmd_ready = !r_busy && (i_cmd_load || !r_ovalid || i_m_tready);
    assign w_pop       = i_cmd_valid && o_cmd_ready;

    // one restoring-division step per cycle on each axis
    assign w_ge_x   = (r_rem_x >= {1'b0, r_steps});
    assign w_ge_y   = (r_rem_y >= {1'b0, r_steps});
    assign w_sub_x  = r_rem_x - {1'b0, r_steps};
    assign w_sub_y  = r_rem_y - {1'b0, r_steps};
    assign w_keep_x = w_ge_x ? w_sub_x : r_rem_x;
    assign w_keep_y = w_ge_y ? w_sub_y : r_rem_y;
    assign w_qn_x   = {r_q_x[F-1:0], w_ge_x};
    assign w_qn_y   = {r_q_y[F-1:0], w_ge_y};

    // round half up
    assign w_rnd_x = r_pos_x + HALF;
    assign w_rnd_y = r_pos_y + HALF;

    always_comb begin
        n_busy   = r_busy;
        n_cnt    = r_cnt;
        n_rem_x  = r_rem_x;
        n_rem_y  = r_rem_y;
        n_q_x    = r_q_x;
        n_q_y    = r_q_y;
        n_steps  = r_steps;
        n_neg_x  = r_neg_x;
        n_neg_y  = r_neg_y;
        n_pos_x  = r_pos_x;
        n_pos_y  = r_pos_y;
        n_inc_x  = r_inc_x;
        n_inc_y  = r_inc_y;
        n_pts    = r_pts;
        n_active = r_active;
        n_ovalid = r_ovalid;
        n_px     = r_px;
        n_py     = r_py;
        n_olast  = r_olast;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        if (r_busy) begin
            n_rem_x = {w_keep_x[C-1:0], 1'b0};
            n_rem_y = {w_keep_y[C-1:0], 1'b0};
            n_q_x   = w_qn_x;
            n_q_y   = w_qn_y;
            if (r_cnt == '0) begin
                n_busy  = 1'b0;
                n_inc_x = r_neg_x ? -{1'b0, w_qn_x} : {1'b0, w_qn_x};
                n_inc_y = r_neg_y ? -{1'b0, w_qn_y} : {1'b0, w_qn_y};
            end else begin
                n_cnt = r_cnt - CNT_W'(1);
            end
        end else if (w_pop) begin
            if (i_cmd_load) begin
                n_pos_x  = {2'b00, i_sx, F'(0)};
                n_pos_y  = {2'b00, i_sy, F'(0)};
                n_pts    = {1'b0, i_steps} + (C+1)'(1);
                n_active = 1'b1;
                n_steps  = i_steps;
                n_neg_x  = i_neg_x;
                n_neg_y  = i_neg_y;
                n_rem_x  = {1'b0, i_ax};
                n_rem_y  = {1'b0, i_ay};
                n_q_x    = '0;
                n_q_y    = '0;
                n_inc_x  = '0;
                n_inc_y  = '0;
                if (i_steps != '0) begin
                    n_busy = 1'b1;
                    n_cnt  = CNT_W'(F);
                end
            end else if (r_active) begin
                n_ovalid = 1'b1;
                n_px     = w_rnd_x[F+C-1:F];
                n_py     = w_rnd_y[F+C-1:F];
                n_olast  = (r_pts == (C+1)'(1));
                n_pts    = r_pts - (C+1)'(1);
                if (r_pts == (C+1)'(1)) begin
                    n_active = 1'b0;
                end else begin
                    n_pos_x = r_pos_x + {{C{r_inc_x[INC_W-1]}}, r_inc_x};
                    n_pos_y = r_pos_y + {{C{r_inc_y[INC_W-1]}}, r_inc_y};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_inc_x  <= '0;
            r_inc_y  <= '0;
            r_pts    <= '0;
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_cnt    <= n_cnt;
            r_pos_x  <= n_pos_x;
            r_pos_y  <= n_pos_y;
            r_inc_x  <= n_inc_x;
            r_inc_y  <= n_inc_y;
            r_pts    <= n_pts;
            r_active <= n_active;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem_x <= n_rem_x;
        r_rem_y <= n_rem_y;
        r_q_x   <= n_q_x;
        r_q_y   <= n_q_y;
        r_steps <= n_steps;
        r_neg_x <= n_neg_x;
        r_neg_y <= n_neg_y;
        r_px    <= n_px;
        r_py    <= n_py;
        r_olast <= n_olast;
    end

    assign o_m_tvalid   = r_ovalid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_last_point = r_olast;

    a_active_pts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_pts != '0))
        else $error("active line with no points left");

    a_div_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !w_pop)
        else $error("command taken during division");

    a_load_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_cmd_load && (i_steps != '0)) |=> (r_busy && r_active))
        else $error("load did not start the divider");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !i_cmd_load && r_active && (r_pts == (C+1)'(1)))
        |=> (!r_active && r_ovalid && r_olast))
        else $error("final pixel did not end the line");

endmodule

FILE: design/dda_line_rasterizer_core.sv
// Top level of the DDA line rasterizer: stream ports, front end and back end.
// Depends on drl_pkg, drl_front and drl_back.
//
// Usage:
//   Slave channel s_axis carries one item per handshake. tuser holds the mode:
//   0 loads a line from (start_x,start_y) to (end_x,end_y), 1 asks for the next pixel.
//   A load gives no result; each advance on an active line gives one pixel on the
//   master channel m_axis, with tlast set on the line's end point. An advance with
//   no line active is dropped. A new load replaces the current line.
//   With the queue empty, an accepted advance is written into the queue, then taken by
//   the back end, which registers its pixel in the output register that drives m_axis.
//   Advances go through one per cycle while the queue is not full, the back end is not
//   dividing and the output register is free or being read. A load with distinct
//   endpoints keeps the back end busy while the restoring divider forms both increments,
//   one quotient bit per cycle; equal endpoints start no division.
//   A four-entry queue sits between front and back, so items keep coming in while
//   the divider runs or the receiver stalls, until the queue fills; then
//   s_axis_tready drops. A stalled result holds in the output register.
//   Reset (synchronous, active low) empties the queue, drops any line and clears
//   the output valid.
module dda_line_rasterizer_core #(
    parameter int COORD_BITS = drl_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = drl_pkg::FRAC_BITS_DEF,
    parameter int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    parameter int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata from bit 0: start_x, start_y, end_x, end_y, zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: mode
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata from bit 0: pixel_x, pixel_y, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tlast: last_point
    output logic                  m_axis_tlast
);
    import drl_pkg::*;

    localparam int C = COORD_BITS;

    logic         w_cmd_valid;
    logic         w_cmd_ready;
    logic         w_cmd_load;
    logic [C-1:0] w_sx;
    logic [C-1:0] w_sy;
    logic [C-1:0] w_ax;
    logic [C-1:0] w_ay;
    logic         w_neg_x;
    logic         w_neg_y;
    logic [C-1:0] w_steps;
    logic [C-1:0] w_pixel_x;
    logic [C-1:0] w_pixel_y;

    // classify and queue incoming items
    drl_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_start_x   (s_axis_tdata[C-1:0]),
        .i_start_y   (s_axis_tdata[2*C-1:C]),
        .i_end_x     (s_axis_tdata[3*C-1:2*C]),
        .i_end_y     (s_axis_tdata[4*C-1:3*C]),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd_load  (w_cmd_load),
        .o_sx        (w_sx),
        .o_sy        (w_sy),
        .o_ax        (w_ax),
        .o_ay        (w_ay),
        .o_neg_x     (w_neg_x),
        .o_neg_y     (w_neg_y),
        .o_steps     (w_steps)
    );

    // divide on load, step and round on advance
    drl_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .o_cmd_ready  (w_cmd_ready),
        .i_cmd_load   (w_cmd_load),
        .i_sx         (w_sx),
        .i_sy         (w_sy),
        .i_ax         (w_ax),
        .i_ay         (w_ay),
        .i_neg_x      (w_neg_x),
        .i_neg_y      (w_neg_y),
        .i_steps      (w_steps),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_pixel_x    (w_pixel_x),
        .o_pixel_y    (w_pixel_y),
        .o_last_point (m_axis_tlast)
    );

    // pack the pixel, zero fill to whole bytes
    assign m_axis_tdata = OUT_DATA_W'({w_pixel_y, w_pixel_x});

endmodule
